FILE: rtl/uts_pkg.sv
// Shared types and constants for the UART transceiver with channel split.
// Used by the configuration, receiver, transmitter and top-level modules.
package uts_pkg;

  localparam int DEFAULT_DIVISOR_WIDTH = 24;
  localparam int CFG_IDX_W = 3;
  localparam int RX_W = 11;
  localparam int TX_W = 13;
  localparam int TSF_W = 26;
  localparam int CNT_MIN_W = 27;

  localparam int BAUD_RESET = 25;
  localparam logic [3:0] DATA_BITS_RESET = 4'd8;
  localparam logic [1:0] STOP_BITS_RESET = 2'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BAUD_DIVISOR  = 3'd0,
    CFG_DATA_BITS     = 3'd1,
    CFG_STOP_BITS     = 3'd2,
    CFG_PARITY_ENABLE = 3'd3,
    CFG_PARITY_FIXED  = 3'd4,
    CFG_PARITY_EVEN   = 3'd5
  } cfg_reg_e;

  // Effective character format after clamping of the raw registers.
  typedef struct packed {
    logic [3:0] data_bits;
    logic [3:0] total_bits;
    logic       parity_enable;
    logic       parity_fixed;
    logic       parity_even;
  } frame_t;

  typedef struct packed {
    logic       recv_valid;
    logic [6:0] recv_char;
    logic       recv_is_command;
  } rx_res_t;

  typedef struct packed {
    logic line_out;
    logic send_taken;
  } tx_res_t;

endpackage

FILE: rtl/uart_transceiver_with_channel_split.sv
// Top level of the UART transceiver with command/console channel split.
// Instantiates uts_cfg, uts_rx and uts_tx; depends on uts_pkg.
//
// Each item is one tick of the serial line. The block takes one item per
// clock while the result side does not stall. The item is held in an input
// register, and the receiver and transmitter step logic update their state
// from it. When the item advances, the outcome lands in a result register,
// from which it is taken. An item can enter every cycle as long as the
// result register is drained. A stall on the result side holds the input
// register and stalls the input.
// Configuration registers are written through a plain write port and must
// only change while no item is in flight.
module uart_transceiver_with_channel_split #(
  parameter int DIVISOR_WIDTH = uts_pkg::DEFAULT_DIVISOR_WIDTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [uts_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DIVISOR_WIDTH-1:0]      cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          line_in_i,
  input  logic                          send_valid_i,
  input  logic [7:0]                    send_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          line_out_o,
  output logic                          send_taken_o,
  output logic                          recv_valid_o,
  output logic [6:0]                    recv_char_o,
  output logic                          recv_is_command_o
);
  import uts_pkg::*;

  logic                     in_valid_q;
  logic                     line_q;
  logic                     send_valid_q;
  logic [7:0]               send_byte_q;
  logic                     out_valid_q;
  rx_res_t                  rx_res, rx_res_q;
  tx_res_t                  tx_res, tx_res_q;
  logic [DIVISOR_WIDTH-1:0] baud;
  frame_t                   frame;
  logic                     advance;
  logic                     in_accept;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  uts_cfg #(.DIVISOR_WIDTH(DIVISOR_WIDTH)) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .baud_o      (baud),
    .frame_o     (frame)
  );

  uts_rx #(.DIVISOR_WIDTH(DIVISOR_WIDTH)) u_rx (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .line_i  (line_q),
    .baud_i  (baud),
    .frame_i (frame),
    .res_o   (rx_res)
  );

  uts_tx #(.DIVISOR_WIDTH(DIVISOR_WIDTH)) u_tx (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .send_valid_i (send_valid_q),
    .send_byte_i  (send_byte_q),
    .baud_i       (baud),
    .frame_i      (frame),
    .res_o        (tx_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      line_q       <= line_in_i;
      send_valid_q <= send_valid_i;
      send_byte_q  <= send_byte_i;
    end
    if (advance) begin
      rx_res_q <= rx_res;
      tx_res_q <= tx_res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign line_out_o        = tx_res_q.line_out;
  assign send_taken_o      = tx_res_q.send_taken;
  assign recv_valid_o      = rx_res_q.recv_valid;
  assign recv_char_o       = rx_res_q.recv_char;
  assign recv_is_command_o = rx_res_q.recv_is_command;

endmodule

FILE: rtl/uts_cfg.sv
// Configuration registers and derived character format.
// Depends on uts_pkg.
module uts_cfg #(
  parameter int DIVISOR_WIDTH = uts_pkg::DEFAULT_DIVISOR_WIDTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [uts_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [DIVISOR_WIDTH-1:0]       cfg_data_i,
  output logic [DIVISOR_WIDTH-1:0]       baud_o,
  output uts_pkg::frame_t                frame_o
);
  import uts_pkg::*;

  logic [DIVISOR_WIDTH-1:0] baud_q;
  logic [3:0]               data_bits_q;
  logic [1:0]               stop_bits_q;
  logic                     par_en_q;
  logic                     par_fix_q;
  logic                     par_even_q;
  logic [3:0]               nb;
  logic [3:0]               ns;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      baud_q      <= DIVISOR_WIDTH'(BAUD_RESET);
      data_bits_q <= DATA_BITS_RESET;
      stop_bits_q <= STOP_BITS_RESET;
      par_en_q    <= 1'b0;
      par_fix_q   <= 1'b0;
      par_even_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_BAUD_DIVISOR:  baud_q      <= cfg_data_i;
        CFG_DATA_BITS:     data_bits_q <= cfg_data_i[3:0];
        CFG_STOP_BITS:     stop_bits_q <= cfg_data_i[1:0];
        CFG_PARITY_ENABLE: par_en_q    <= cfg_data_i[0];
        CFG_PARITY_FIXED:  par_fix_q   <= cfg_data_i[0];
        CFG_PARITY_EVEN:   par_even_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (data_bits_q < 4'd5) begin
      nb = 4'd5;
    end else if (data_bits_q > 4'd8) begin
      nb = 4'd8;
    end else begin
      nb = data_bits_q;
    end
    case (stop_bits_q)
      2'd0:    ns = 4'd1;
      2'd3:    ns = 4'd2;
      default: ns = {2'b00, stop_bits_q};
    endcase
    baud_o = (baud_q == '0) ? DIVISOR_WIDTH'(1) : baud_q;
    frame_o.data_bits     = nb;
    frame_o.total_bits    = nb + {3'b000, par_en_q} + ns;
    frame_o.parity_enable = par_en_q;
    frame_o.parity_fixed  = par_fix_q;
    frame_o.parity_even   = par_even_q;
  end

endmodule

FILE: rtl/uts_rx.sv
// Receiver: start detection, mid-bit sampling and channel split of one byte.
// Depends on uts_pkg; state advances once per processed item.
module uts_rx #(
  parameter int DIVISOR_WIDTH = uts_pkg::DEFAULT_DIVISOR_WIDTH
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     step_i,
  input  logic                     line_i,
  input  logic [DIVISOR_WIDTH-1:0] baud_i,
  input  uts_pkg::frame_t          frame_i,
  output uts_pkg::rx_res_t         res_o
);
  import uts_pkg::*;

  localparam int CW = (DIVISOR_WIDTH + 2 > CNT_MIN_W) ? DIVISOR_WIDTH + 2 : CNT_MIN_W;
  localparam logic [TSF_W-1:0] TsfMax = '1;

  logic                 active_q, active_d;
  logic signed [CW-1:0] cnt_q, cnt_d;
  logic [TSF_W-1:0]     tsf_q, tsf_d;
  logic                 prev_q, prev_d;
  logic [3:0]           samples_q, samples_d;
  logic [RX_W-1:0]      shift_q, shift_d;
  logic [3:0]           shr;
  logic [7:0]           ch;
  logic                 cnt_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      cnt_q     <= '0;
      tsf_q     <= '0;
      prev_q    <= 1'b1;
      samples_q <= '0;
      shift_q   <= '0;
    end else begin
      active_q  <= active_d;
      cnt_q     <= cnt_d;
      tsf_q     <= tsf_d;
      prev_q    <= prev_d;
      samples_q <= samples_d;
      shift_q   <= shift_d;
    end
  end

  always_comb begin
    shr      = 4'(RX_W) - frame_i.total_bits;
    ch       = 8'(shift_q >> shr);
    cnt_done = cnt_q[CW-1] || (cnt_q == '0);

    active_d  = active_q;
    cnt_d     = cnt_q;
    tsf_d     = tsf_q;
    prev_d    = prev_q;
    samples_d = samples_q;
    shift_d   = shift_q;
    res_o     = '0;

    if (step_i) begin
      prev_d = line_i;
      if (!line_i && prev_q) begin
        tsf_d = '0;
      end else if (tsf_q != TsfMax) begin
        tsf_d = tsf_q + 1'b1;
      end

      if (!active_q) begin
        if (!line_i) begin
          active_d  = 1'b1;
          cnt_d     = CW'(baud_i) + CW'(baud_i >> 1) - CW'(1) - CW'(tsf_d);
          samples_d = '0;
          shift_d   = '0;
        end
      end else if (cnt_done) begin
        if (samples_q >= frame_i.total_bits) begin
          active_d              = 1'b0;
          res_o.recv_valid      = 1'b1;
          res_o.recv_char       = ch[6:0];
          res_o.recv_is_command = ch[7];
        end else begin
          samples_d = samples_q + 1'b1;
          shift_d   = {line_i, shift_q[RX_W-1:1]};
        end
        cnt_d = CW'(baud_i) - CW'(1);
      end else begin
        cnt_d = cnt_q - CW'(1);
      end
    end
  end

endmodule

FILE: rtl/uts_tx.sv
// Transmitter: frames a byte with start, data, optional parity and stop bits.
// Depends on uts_pkg; state advances once per processed item.
module uts_tx #(
  parameter int DIVISOR_WIDTH = uts_pkg::DEFAULT_DIVISOR_WIDTH
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     step_i,
  input  logic                     send_valid_i,
  input  logic [7:0]               send_byte_i,
  input  logic [DIVISOR_WIDTH-1:0] baud_i,
  input  uts_pkg::frame_t          frame_i,
  output uts_pkg::tx_res_t         res_o
);
  import uts_pkg::*;

  logic                     active_q, active_d;
  logic [DIVISOR_WIDTH-1:0] cnt_q, cnt_d;
  logic [TX_W-1:0]          shift_q, shift_d;
  logic [3:0]               left_q, left_d;
  logic [7:0]               mask;
  logic [7:0]               payload;
  logic                     par_bit;
  logic [3:0]               stop_pos;
  logic [TX_W-1:0]          frame;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      cnt_q    <= '0;
      shift_q  <= '1;
      left_q   <= '0;
    end else begin
      active_q <= active_d;
      cnt_q    <= cnt_d;
      shift_q  <= shift_d;
      left_q   <= left_d;
    end
  end

  always_comb begin
    mask     = 8'((9'd1 << frame_i.data_bits) - 9'd1);
    payload  = send_byte_i & mask;
    par_bit  = frame_i.parity_fixed ? frame_i.parity_even : (^payload) ^ frame_i.parity_even;
    stop_pos = frame_i.data_bits + {3'b000, frame_i.parity_enable} + 4'd1;
    frame    = {{(TX_W-9){1'b0}}, payload, 1'b0};
    if (frame_i.parity_enable) begin
      frame = frame | (TX_W'(par_bit) << (frame_i.data_bits + 4'd1));
    end
    frame = frame | ({TX_W{1'b1}} << stop_pos);

    active_d = active_q;
    cnt_d    = cnt_q;
    shift_d  = shift_q;
    left_d   = left_q;
    res_o    = '{line_out: 1'b1, send_taken: 1'b0};

    if (step_i) begin
      if (!active_q) begin
        if (send_valid_i) begin
          shift_d          = frame;
          left_d           = frame_i.total_bits + 4'd1;
          active_d         = 1'b1;
          cnt_d            = baud_i - 1'b1;
          res_o.send_taken = 1'b1;
          res_o.line_out   = 1'b0;
        end
      end else if (cnt_q == '0) begin
        shift_d = {1'b1, shift_q[TX_W-1:1]};
        if (left_q != '0) begin
          left_d = left_q - 1'b1;
        end
        if (left_d == '0) begin
          active_d = 1'b0;
        end else begin
          cnt_d = baud_i - 1'b1;
        end
        res_o.line_out = shift_d[0];
      end else begin
        cnt_d          = cnt_q - 1'b1;
        res_o.line_out = shift_q[0];
      end
    end
  end

endmodule
